/* src/hsl2rgb_pkg.sv */
// Package of shared types and constants for the HSL to RGB pixel converter.
package hsl2rgb_pkg;

	localparam int SECTOR_BITS = 3;

	typedef logic [SECTOR_BITS-1:0] sector_t;

	localparam sector_t SECTOR_RED_YELLOW     = 3'd0;
	localparam sector_t SECTOR_YELLOW_GREEN   = 3'd1;
	localparam sector_t SECTOR_GREEN_CYAN     = 3'd2;
	localparam sector_t SECTOR_CYAN_BLUE      = 3'd3;
	localparam sector_t SECTOR_BLUE_MAGENTA   = 3'd4;
	localparam sector_t SECTOR_MAGENTA_RED    = 3'd5;

endpackage

/* src/hsl2rgb_prep.sv */
// First pipeline stage: chroma span, hue sector and secondary weighting factor.
module hsl2rgb_prep #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  logic [CHANNEL_BITS-1:0]    hue,
	input  logic [CHANNEL_BITS-1:0]    saturation,
	input  logic [CHANNEL_BITS-1:0]    luminance,
	output logic                       valid_s1,
	output logic [CHANNEL_BITS:0]      span_s1,
	output logic [CHANNEL_BITS-1:0]    sat_s1,
	output logic [CHANNEL_BITS-1:0]    lum_s1,
	output hsl2rgb_pkg::sector_t       sector_s1,
	output logic [CHANNEL_BITS:0]      factor_s1
);

	localparam int W = CHANNEL_BITS;
	localparam logic [W:0] ONE = {1'b1, {W{1'b0}}};

	logic [W:0]   lum_ext;
	logic [W:0]   compl;
	logic [W:0]   lo;
	logic [W:0]   span;
	logic [W+2:0] h6;
	hsl2rgb_pkg::sector_t sector;
	logic [W-1:0] frac;
	logic [W:0]   factor;

	assign lum_ext = {1'b0, luminance};
	assign compl   = ONE - lum_ext;
	assign lo      = (lum_ext < compl) ? lum_ext : compl;
	assign span    = {lo[W-1:0], 1'b0};
	assign h6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
	assign sector  = h6[W+2:W];
	assign frac    = h6[W-1:0];
	assign factor  = sector[0] ? (ONE - {1'b0, frac}) : {1'b0, frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		span_s1   <= span;
		sat_s1    <= saturation;
		lum_s1    <= luminance;
		sector_s1 <= sector;
		factor_s1 <= factor;
	end

endmodule

/* src/hsl2rgb_mulsh.sv */
// Registered multiply with a fixed right shift, one pipeline stage.
module hsl2rgb_mulsh #(
	parameter int A_BITS   = 17,
	parameter int B_BITS   = 16,
	parameter int SHIFT    = 16,
	parameter int OUT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  logic [A_BITS-1:0]   a,
	input  logic [B_BITS-1:0]   b,
	output logic                valid_out,
	output logic [OUT_BITS-1:0] p
);

	logic [A_BITS+B_BITS-1:0] prod;

	assign prod = {{B_BITS{1'b0}}, a} * {{A_BITS{1'b0}}, b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		p <= prod[SHIFT+OUT_BITS-1:SHIFT];
	end

endmodule

/* src/hsl2rgb_mix.sv */
// Last pipeline stage: places chroma and secondary value, adds the offset and saturates.
module hsl2rgb_mix #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	input  logic [CHANNEL_BITS-1:0]  chroma,
	input  logic [CHANNEL_BITS-1:0]  x,
	input  logic [CHANNEL_BITS-1:0]  lum,
	input  hsl2rgb_pkg::sector_t     sector,
	output logic                     done,
	output logic [CHANNEL_BITS-1:0]  red,
	output logic [CHANNEL_BITS-1:0]  green,
	output logic [CHANNEL_BITS-1:0]  blue
);

	localparam int W = CHANNEL_BITS;

	logic [W-1:0]        rc;
	logic [W-1:0]        gc;
	logic [W-1:0]        bc;
	logic signed [W+1:0] m;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] c, input logic signed [W+1:0] o);
		logic signed [W+2:0] sum;
		begin
			sum = $signed({3'b000, c}) + $signed({o[W+1], o});
			if (sum[W+2]) begin
				sat_add = '0;
			end else if (sum[W+1:W] != 2'b00) begin
				sat_add = '1;
			end else begin
				sat_add = sum[W-1:0];
			end
		end
	endfunction

	always_comb begin
		case (sector)
			hsl2rgb_pkg::SECTOR_RED_YELLOW: begin
				rc = chroma; gc = x;      bc = '0;
			end
			hsl2rgb_pkg::SECTOR_YELLOW_GREEN: begin
				rc = x;      gc = chroma; bc = '0;
			end
			hsl2rgb_pkg::SECTOR_GREEN_CYAN: begin
				rc = '0;     gc = chroma; bc = x;
			end
			hsl2rgb_pkg::SECTOR_CYAN_BLUE: begin
				rc = '0;     gc = x;      bc = chroma;
			end
			hsl2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
				rc = x;      gc = '0;     bc = chroma;
			end
			default: begin
				rc = chroma; gc = '0;     bc = x;
			end
		endcase
	end

	assign m = $signed({2'b00, lum}) - $signed({3'b000, chroma[W-1:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid;
		end
	end

	always_ff @(posedge clk) begin
		red   <= sat_add(rc, m);
		green <= sat_add(gc, m);
		blue  <= sat_add(bc, m);
	end

endmodule

/* src/hsl_to_rgb_pixel_converter_top.sv */
// Top level of the HSL to RGB pixel converter.
// The converter takes one HSL word in every clock cycle and never asserts busy. Each word
// passes four register stages (span and sector, chroma multiply, secondary multiply, channel
// mix), and its RGB word appears on red, green and blue, with done high for one cycle only,
// once the channel mix register takes it. The two multipliers set the stage depth.
module hsl_to_rgb_pixel_converter_top #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [CHANNEL_BITS-1:0]  hue,
	input  logic [CHANNEL_BITS-1:0]  saturation,
	input  logic [CHANNEL_BITS-1:0]  luminance,
	output logic                     done,
	output logic [CHANNEL_BITS-1:0]  red,
	output logic [CHANNEL_BITS-1:0]  green,
	output logic [CHANNEL_BITS-1:0]  blue
);

	localparam int W = CHANNEL_BITS;

	logic                 valid_s1;
	logic [W:0]           span_s1;
	logic [W-1:0]         sat_s1;
	logic [W-1:0]         lum_s1;
	hsl2rgb_pkg::sector_t sector_s1;
	logic [W:0]           factor_s1;

	logic                 valid_s2;
	logic [W-1:0]         chroma_s2;
	logic [W-1:0]         lum_s2;
	hsl2rgb_pkg::sector_t sector_s2;
	logic [W:0]           factor_s2;

	logic                 valid_s3;
	logic [W-1:0]         x_s3;
	logic [W-1:0]         chroma_s3;
	logic [W-1:0]         lum_s3;
	hsl2rgb_pkg::sector_t sector_s3;

	assign busy = 1'b0;

	hsl2rgb_prep #(.CHANNEL_BITS(W)) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (start & ~busy),
		.hue        (hue),
		.saturation (saturation),
		.luminance  (luminance),
		.valid_s1   (valid_s1),
		.span_s1    (span_s1),
		.sat_s1     (sat_s1),
		.lum_s1     (lum_s1),
		.sector_s1  (sector_s1),
		.factor_s1  (factor_s1)
	);

	hsl2rgb_mulsh #(.A_BITS(W+1), .B_BITS(W), .SHIFT(W), .OUT_BITS(W)) u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.a         (span_s1),
		.b         (sat_s1),
		.valid_out (valid_s2),
		.p         (chroma_s2)
	);

	always_ff @(posedge clk) begin
		lum_s2    <= lum_s1;
		sector_s2 <= sector_s1;
		factor_s2 <= factor_s1;
	end

	hsl2rgb_mulsh #(.A_BITS(W+1), .B_BITS(W), .SHIFT(W), .OUT_BITS(W)) u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.a         (factor_s2),
		.b         (chroma_s2),
		.valid_out (valid_s3),
		.p         (x_s3)
	);

	always_ff @(posedge clk) begin
		chroma_s3 <= chroma_s2;
		lum_s3    <= lum_s2;
		sector_s3 <= sector_s2;
	end

	hsl2rgb_mix #(.CHANNEL_BITS(W)) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s3),
		.chroma (chroma_s3),
		.x      (x_s3),
		.lum    (lum_s3),
		.sector (sector_s3),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule

/* src/hsl2rgb_checker.sv */
// Port-level checker for the HSL to RGB pixel converter, with its bind statement.
module hsl2rgb_checker #(
	parameter int CHANNEL_BITS = 16
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [CHANNEL_BITS-1:0]  hue,
	input logic [CHANNEL_BITS-1:0]  saturation,
	input logic [CHANNEL_BITS-1:0]  luminance,
	input logic                     done,
	input logic [CHANNEL_BITS-1:0]  red,
	input logic [CHANNEL_BITS-1:0]  green,
	input logic [CHANNEL_BITS-1:0]  blue
);

	logic accept;

	assign accept = start && !busy;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("Converter refused a word.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n) accept |-> ##4 done)
		else $error("Result word did not appear four cycles after start.");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && saturation == '0) |-> ##4 (red == $past(luminance, 4)
			&& green == $past(luminance, 4) && blue == $past(luminance, 4)))
		else $error("Zero saturation did not give grey at the luminance.");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && luminance == '0) |-> ##4 (red == '0 && green == '0 && blue == '0))
		else $error("Zero luminance did not give black.");

	a_hue_free_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && saturation == '0 && hue != '0) |-> ##4 (red == green && green == blue))
		else $error("Hue changed a grey word.");

endmodule

bind hsl_to_rgb_pixel_converter_top hsl2rgb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_checker (.*);

/* dv/tb_hsl_to_rgb_pixel_converter_top.sv */
// Self-checking testbench for the HSL to RGB pixel converter, with its own conversion model.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_pixel_converter_top;

	localparam int W = 16;
	localparam int ONE = 1 << W;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_WORDS = 850;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [W-1:0] red;
		logic [W-1:0] green;
		logic [W-1:0] blue;
	} rgb_word_t;

	class pixel_scoreboard;
		rgb_word_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function logic [W-1:0] clamp_channel(input longint v);
			if (v < 0)
				return '0;
			if (v > ONE - 1)
				return W'(ONE - 1);
			return W'(v);
		endfunction

		function rgb_word_t hsl_to_rgb(input logic [W-1:0] h, s, l);
			logic [W:0] lo;
			logic [W+1:0] span;
			logic [W-1:0] chroma;
			logic [W+2:0] h6;
			hsl2rgb_pkg::sector_t sector;
			logic [W-1:0] frac;
			logic [W:0] factor;
			logic [W-1:0] x;
			logic [W-1:0] rc, gc, bc;
			longint m;
			rgb_word_t res;
			if (s == 0) begin
				res.red = l;
				res.green = l;
				res.blue = l;
				return res;
			end
			lo = (l < (ONE - l)) ? (W+1)'(l) : (W+1)'(ONE - l);
			span = {lo, 1'b0};
			chroma = W'((64'(span) * 64'(s)) >> W);
			h6 = (W+3)'(h) * (W+3)'(6);
			sector = hsl2rgb_pkg::sector_t'(h6 >> W);
			frac = h6[W-1:0];
			factor = sector[0] ? (W+1)'(ONE - frac) : {1'b0, frac};
			x = W'((64'(chroma) * 64'(factor)) >> W);
			case (sector)
				hsl2rgb_pkg::SECTOR_RED_YELLOW: begin
					rc = chroma; gc = x; bc = '0;
				end
				hsl2rgb_pkg::SECTOR_YELLOW_GREEN: begin
					rc = x; gc = chroma; bc = '0;
				end
				hsl2rgb_pkg::SECTOR_GREEN_CYAN: begin
					rc = '0; gc = chroma; bc = x;
				end
				hsl2rgb_pkg::SECTOR_CYAN_BLUE: begin
					rc = '0; gc = x; bc = chroma;
				end
				hsl2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
					rc = x; gc = '0; bc = chroma;
				end
				default: begin
					rc = chroma; gc = '0; bc = x;
				end
			endcase
			m = longint'(l) - longint'(chroma >> 1);
			res.red = clamp_channel(longint'(rc) + m);
			res.green = clamp_channel(longint'(gc) + m);
			res.blue = clamp_channel(longint'(bc) + m);
			return res;
		endfunction

		function void note_pixel(input logic [W-1:0] h, s, l);
			expected_q.push_back(hsl_to_rgb(h, s, l));
		endfunction

		function void check_pixel(input logic [W-1:0] r, g, b);
			rgb_word_t exp_word;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word red %0d green %0d blue %0d", $time, r, g, b);
				errors++;
				return;
			end
			exp_word = expected_q.pop_front();
			if (r !== exp_word.red) begin
				$display("%0t: red expected %0d, got %0d", $time, exp_word.red, r);
				errors++;
			end
			if (g !== exp_word.green) begin
				$display("%0t: green expected %0d, got %0d", $time, exp_word.green, g);
				errors++;
			end
			if (b !== exp_word.blue) begin
				$display("%0t: blue expected %0d, got %0d", $time, exp_word.blue, b);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [W-1:0] hue, saturation, luminance;
	logic done;
	logic [W-1:0] red, green, blue;

	pixel_scoreboard sb = new();
	int quiet_cycles = 0;

	hsl_to_rgb_pixel_converter_top #(
		.CHANNEL_BITS(W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue(hue),
		.saturation(saturation),
		.luminance(luminance),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_pixel(red, green, blue);
			if (start && !busy)
				sb.note_pixel(hue, saturation, luminance);
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [W-1:0] h, s, l);
		@(negedge clk);
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		luminance <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		@(negedge clk);
		start <= 1'b0;
		hue <= W'($urandom);
		saturation <= W'($urandom);
		luminance <= W'($urandom);
	endtask

	function automatic logic [W-1:0] pick_field();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return W'($urandom_range(3));
			3: return W'(ONE - 1 - $urandom_range(3));
			default: return W'($urandom);
		endcase
	endfunction

	int idle_pct[4] = '{0, 56, 0, 8};
	logic [W-1:0] rs;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		hue = '0;
		saturation = '0;
		luminance = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Grey pixels, full-scale and zero inputs, every sector edge at or near half luminance, then mixed words.
		send_pixel('0, '0, '0);
		send_pixel('1, '0, '1);
		send_pixel(16'h1234, '0, 16'h8000);
		send_pixel('0, '1, '1);
		send_pixel('1, '1, '1);
		send_pixel('0, '1, '0);
		send_pixel('1, '1, 16'd1);
		send_pixel(16'd0, '1, 16'h8000);
		send_pixel(16'd10922, '1, 16'h8000);
		send_pixel(16'd10923, '1, 16'h8000);
		send_pixel(16'd21845, '1, 16'h8000);
		send_pixel(16'd21846, '1, 16'h8000);
		send_pixel(16'd32767, '1, 16'h7FFF);
		send_pixel(16'd32768, '1, 16'h7FFF);
		send_pixel(16'd43690, '1, 16'h8001);
		send_pixel(16'd43691, '1, 16'h8001);
		send_pixel(16'd54613, '1, 16'h8000);
		send_pixel(16'd54614, '1, 16'h8000);
		send_pixel('1, '1, 16'h8000);
		send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
		send_pixel(16'h5555, 16'hAAAA, 16'h5555);
		send_pixel(16'd1, 16'd1, 16'hFFFE);

		for (int phase = 0; phase < 4; phase++) begin
			for (int i = 0; i < RANDOM_WORDS / 4; i++) begin
				while ($urandom_range(99) < idle_pct[phase])
					idle_gap();
				rs = ($urandom_range(9) == 0) ? W'(0) : pick_field();
				send_pixel(pick_field(), rs, pick_field());
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* hsl_to_rgb_pixel_converter_top.f */
src/hsl2rgb_pkg.sv
src/hsl2rgb_prep.sv
src/hsl2rgb_mulsh.sv
src/hsl2rgb_mix.sv
src/hsl_to_rgb_pixel_converter_top.sv
src/hsl2rgb_checker.sv
dv/tb_hsl_to_rgb_pixel_converter_top.sv
